FILE: src/vector_average_to_hue_colour_core_defines.svh
// assertion macros for the vector average to hue colour core
// used by vector_average_to_hue_colour_core.sv, needs clk and rst in scope
`ifndef VECTOR_AVERAGE_TO_HUE_COLOUR_CORE_DEFINES_SVH
`define VECTOR_AVERAGE_TO_HUE_COLOUR_CORE_DEFINES_SVH

// same-cycle implication
`define VAHC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VAHC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/vahc_pkg.sv
// constants, register indexes and the cordic angle table for the hue colour core
// no dependencies
package vahc_pkg;

  localparam int FRAMES_DEFAULT = 8;
  localparam int SUM_W          = 22;

  localparam int ONE_Q14 = 16384;
  localparam int S_MIN   = 9830;
  localparam logic signed [32:0] K_Q30 = 33'sd652032874;

  // angles in 1/4096 degree
  localparam int DEG30  = 122880;
  localparam int DEG60  = 245760;
  localparam int DEG120 = 491520;
  localparam int DEG180 = 737280;
  localparam int DEG240 = 983040;
  localparam int DEG300 = 1228800;
  localparam int DEG360 = 1474560;

  localparam int ITER = 16;

  typedef enum logic [1:0] {
    CFG_MANUAL_MODE = 2'd0,
    CFG_ROT_ANGLE   = 2'd1,
    CFG_RADIUS      = 2'd2,
    CFG_SCALE       = 2'd3
  } cfg_idx_t;

  // atan(2^-i) in 1/4096 degree
  function automatic logic [17:0] atan_step(input logic [3:0] i);
    logic [17:0] v;
    case (i)
      4'd0:  v = 18'd184320;
      4'd1:  v = 18'd108810;
      4'd2:  v = 18'd57492;
      4'd3:  v = 18'd29184;
      4'd4:  v = 18'd14649;
      4'd5:  v = 18'd7331;
      4'd6:  v = 18'd3667;
      4'd7:  v = 18'd1833;
      4'd8:  v = 18'd917;
      4'd9:  v = 18'd458;
      4'd10: v = 18'd229;
      4'd11: v = 18'd115;
      4'd12: v = 18'd57;
      4'd13: v = 18'd29;
      4'd14: v = 18'd14;
      default: v = 18'd7;
    endcase
    return v;
  endfunction

endpackage

FILE: src/vector_average_to_hue_colour_core.sv
// channel   dir  payload (low bit up)                                   handshake
// s_axis    in   tdata: arousal[15:0] valence[31:16]                    tvalid/tready
// m_axis    out  tdata: red yellow blue mean_valence mean_arousal pad   tvalid/tready
// cfg       in   cfg_index, cfg_data                                    cfg_valid/cfg_ready
// an item that does not close a run of FRAMES items is added to the sums and the input stays ready
// the closing item starts the computation that raises m_axis_tvalid in auto and manual mode:
// two 16-step cordic passes, a 16-step square root and up to three divides by a constant
// done as reciprocal products on one shared multiplier
// sync reset, active high; the result holds on m_axis until taken, input stalls meanwhile
// configuration is always ready
`include "vector_average_to_hue_colour_core_defines.svh"

module vector_average_to_hue_colour_core #(
  parameter int FRAMES = vahc_pkg::FRAMES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // arousal[15:0], valence[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red[14:0], yellow[29:15], blue[44:30], mean_valence[60:45], mean_arousal[76:61]
  output logic [79:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = $clog2(FRAMES + 1);
  localparam int SW = vahc_pkg::SUM_W;
  // ceil(2^29 / FRAMES), exact floor quotient for dividends below 2^23
  localparam logic signed [32:0] FR_RECIP =
    33'(((longint'(1) << 29) + longint'(FRAMES) - 1) / longint'(FRAMES));
  // ceil(2^26 / 60), exact floor quotient for dividends below 2^20
  localparam logic signed [32:0] X_RECIP = 33'sd1118482;

  typedef enum logic [4:0] {
    ST_IDLE, ST_REDUCE, ST_SINCOS, ST_M_VC, ST_M_AS, ST_MAN_SET, ST_M_VS, ST_M_AC,
    ST_M_TVS, ST_DIV_V_LD, ST_DIV_V, ST_SET_V, ST_A_LD, ST_DIV_A, ST_SET_A, ST_VEC_INIT,
    ST_VEC, ST_HUE, ST_SQ, ST_SQRT_INIT, ST_SQRT, ST_SEC, ST_X_LD, ST_DIV_X,
    ST_SET_X, ST_OUT
  } state_t;

  state_t state;
  logic [3:0] it;
  logic [CW-1:0] frame_count;
  logic signed [SW-1:0] valence_sum, arousal_sum;
  logic manual_mode;
  logic signed [13:0] rotation_angle;
  logic [14:0] manual_radius;
  logic [15:0] scale_factor;

  logic signed [32:0] cx, cy;
  logic signed [21:0] cz;
  logic neg_cs, zero_vec;
  logic signed [58:0] prod;
  logic signed [59:0] acc;
  logic signed [25:0] tv, ta;
  logic signed [15:0] mv, ma;
  logic [20:0] hue;
  logic [32:0] sq_n, sqr_res, sqr_bit;
  logic [22:0] dn;
  logic div_neg;
  logic [14:0] sat_c;
  logic [2:0] sector;
  logic [14:0] red, yellow, blue;
  logic out_valid;

  logic signed [15:0] in_a, in_v;
  logic signed [SW-1:0] vs_next, as_next;
  logic [CW:0] cnt_inc;

  assign in_a = s_axis_tdata[15:0];
  assign in_v = s_axis_tdata[31:16];
  assign vs_next = valence_sum + SW'(in_v);
  assign as_next = arousal_sum + SW'(in_a);
  assign cnt_inc = (CW + 1)'(frame_count) + 1'b1;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {3'b000, ma, mv, blue, yellow, red};

  function automatic logic signed [25:0] rnd30(input logic signed [59:0] v);
    logic signed [59:0] t;
    t = v + 60'sd536870912;
    return 26'(t >>> 30);
  endfunction

  // angle reduction for the rotation cordic
  logic signed [14:0] ra;
  logic ra_neg;
  always_comb begin
    ra = 15'(rotation_angle);
    ra_neg = 1'b0;
    if (ra >= 15'sd5760) ra = ra - 15'sd5760;
    if (ra < 15'sd0) ra = ra + 15'sd5760;
    if (ra < 15'sd0) ra = ra + 15'sd5760;
    if (ra > 15'sd2880) ra = ra - 15'sd5760;
    if (ra > 15'sd1440) begin
      ra = ra - 15'sd2880;
      ra_neg = 1'b1;
    end else if (ra < -15'sd1440) begin
      ra = ra + 15'sd2880;
      ra_neg = 1'b1;
    end
  end

  // shared multiplier operand select
  logic signed [32:0] c_val, s_val;
  logic signed [25:0] mul_a;
  logic signed [32:0] mul_b;
  logic mul_en;
  logic [14:0] sm_comb;
  logic [20:0] h_mod;
  logic signed [21:0] tm;
  logic [17:0] tm_abs, x_diff;
  logic [2:0] sec_comb;

  assign c_val = neg_cs ? -cx : cx;
  assign s_val = neg_cs ? -cy : cy;

  always_comb begin
    if (sqr_res[16:0] < 17'(vahc_pkg::S_MIN)) sm_comb = 15'(vahc_pkg::S_MIN);
    else if (sqr_res[16:0] > 17'(vahc_pkg::ONE_Q14)) sm_comb = 15'(vahc_pkg::ONE_Q14);
    else sm_comb = sqr_res[14:0];
    if (hue < 21'(vahc_pkg::DEG60)) sec_comb = 3'd0;
    else if (hue < 21'(vahc_pkg::DEG120)) sec_comb = 3'd1;
    else if (hue < 21'(vahc_pkg::DEG180)) sec_comb = 3'd2;
    else if (hue < 21'(vahc_pkg::DEG240)) sec_comb = 3'd3;
    else if (hue < 21'(vahc_pkg::DEG300)) sec_comb = 3'd4;
    else sec_comb = 3'd5;
    case (sec_comb)
      3'd0, 3'd1: h_mod = hue;
      3'd2, 3'd3: h_mod = hue - 21'(vahc_pkg::DEG120);
      default:    h_mod = hue - 21'(vahc_pkg::DEG240);
    endcase
    tm = signed'({1'b0, h_mod}) - 22'sd245760;
    tm_abs = (tm < 22'sd0) ? 18'(-tm) : 18'(tm);
    x_diff = 18'(vahc_pkg::DEG60) - tm_abs;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_en = 1'b1;
    case (state)
      ST_M_VC: begin
        mul_a = manual_mode ? 26'(signed'({1'b0, manual_radius})) : 26'(valence_sum);
        mul_b = c_val;
      end
      ST_M_AS: begin
        mul_a = manual_mode ? 26'(signed'({1'b0, manual_radius})) : 26'(arousal_sum);
        mul_b = s_val;
      end
      ST_M_VS: begin
        mul_a = 26'(valence_sum);
        mul_b = s_val;
      end
      ST_M_AC: begin
        mul_a = 26'(arousal_sum);
        mul_b = c_val;
      end
      ST_M_TVS: begin
        mul_a = tv;
        mul_b = 33'(signed'({1'b0, scale_factor}));
      end
      ST_SET_V: begin
        mul_a = ta;
        mul_b = 33'(signed'({1'b0, scale_factor}));
      end
      ST_DIV_V, ST_DIV_A: begin
        mul_a = signed'({3'b000, dn});
        mul_b = FR_RECIP;
      end
      ST_DIV_X: begin
        mul_a = signed'({3'b000, dn});
        mul_b = X_RECIP;
      end
      ST_HUE: begin
        mul_a = 26'(mv);
        mul_b = 33'(mv);
      end
      ST_SQ: begin
        mul_a = 26'(ma);
        mul_b = 33'(ma);
      end
      ST_SEC: begin
        mul_a = 26'(signed'({1'b0, sm_comb}));
        mul_b = 33'(signed'({1'b0, x_diff}));
      end
      default: mul_en = 1'b0;
    endcase
  end

  // dividend load: rounded, shifted by 12, sign folded for a floor quotient
  logic signed [59:0] dv_sh;
  logic signed [32:0] dv;
  logic [32:0] ld_mag;
  logic ld_neg;
  logic [22:0] dn_load;
  always_comb begin
    if (state == ST_X_LD) dv_sh = (60'(prod) + 60'sd122880) >>> 12;
    else dv_sh = (60'(prod) + 60'(FRAMES * 2048)) >>> 12;
    dv = 33'(dv_sh);
    ld_neg = dv[32];
    ld_mag = ld_neg ? 33'(-dv) + 33'(FRAMES - 1) : 33'(dv);
  end
  // large dividends saturate the result anyway
  assign dn_load = (ld_mag > 33'd8388607) ? 23'h7fffff : ld_mag[22:0];

  logic [23:0] q_fr;
  logic signed [32:0] quot;
  logic signed [15:0] quot_sat;
  assign q_fr = prod[52:29];
  assign quot = div_neg ? -signed'(33'(q_fr)) : signed'(33'(q_fr));
  always_comb begin
    if (quot < -33'sd32768) quot_sat = -16'sd32768;
    else if (quot > 33'sd16384) quot_sat = 16'sd16384;
    else quot_sat = 16'(quot);
  end

  logic signed [25:0] man_v, man_a;
  logic signed [15:0] man_v_sat, man_a_sat;
  assign man_v = rnd30(acc);
  assign man_a = rnd30(60'(prod));
  always_comb begin
    if (man_v < -26'sd32768) man_v_sat = -16'sd32768;
    else if (man_v > 26'sd32767) man_v_sat = 16'sd32767;
    else man_v_sat = 16'(man_v);
    if (man_a < -26'sd32768) man_a_sat = -16'sd32768;
    else if (man_a > 26'sd32767) man_a_sat = 16'sd32767;
    else man_a_sat = 16'(man_a);
  end

  logic signed [21:0] h0, h1;
  always_comb begin
    h0 = (zero_vec ? 22'sd0 : cz) + 22'sd122880;
    h1 = h0;
    if (h1 < 22'sd0) h1 = h1 + 22'sd1474560;
    if (h1 >= 22'sd1474560) h1 = h1 - 22'sd1474560;
    if (h1 < 22'sd0) h1 = 22'sd0;
  end

  logic signed [21:0] atan_s;
  logic [32:0] sq_trial;
  logic [14:0] xx, mval;
  assign atan_s = signed'({4'b0000, vahc_pkg::atan_step(it)});
  assign sq_trial = sqr_res + sqr_bit;
  assign xx = prod[40:26];
  assign mval = 15'(vahc_pkg::ONE_Q14) - sat_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      it <= '0;
      frame_count <= '0;
      valence_sum <= '0;
      arousal_sum <= '0;
      manual_mode <= 1'b0;
      rotation_angle <= '0;
      manual_radius <= 15'd16384;
      scale_factor <= 16'd4096;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (vahc_pkg::cfg_idx_t'(cfg_index))
          vahc_pkg::CFG_MANUAL_MODE: manual_mode <= cfg_data[0];
          vahc_pkg::CFG_ROT_ANGLE:   rotation_angle <= cfg_data[13:0];
          vahc_pkg::CFG_RADIUS:      manual_radius <= cfg_data[14:0];
          vahc_pkg::CFG_SCALE:       scale_factor <= cfg_data;
          default: ;
        endcase
      end
      if (mul_en) prod <= mul_a * mul_b;

      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            valence_sum <= vs_next;
            arousal_sum <= as_next;
            if (cnt_inc == (CW + 1)'(FRAMES)) begin
              frame_count <= '0;
              state <= ST_REDUCE;
            end else begin
              frame_count <= CW'(cnt_inc);
            end
          end
        end
        ST_REDUCE: begin
          cx <= vahc_pkg::K_Q30;
          cy <= '0;
          cz <= 22'(ra) <<< 8;
          neg_cs <= ra_neg;
          it <= '0;
          state <= ST_SINCOS;
        end
        ST_SINCOS: begin
          if (cz >= 22'sd0) begin
            cx <= cx - (cy >>> it);
            cy <= cy + (cx >>> it);
            cz <= cz - atan_s;
          end else begin
            cx <= cx + (cy >>> it);
            cy <= cy - (cx >>> it);
            cz <= cz + atan_s;
          end
          it <= it + 1'b1;
          if (it == 4'(vahc_pkg::ITER - 1)) state <= ST_M_VC;
        end
        ST_M_VC: state <= ST_M_AS;
        ST_M_AS: begin
          acc <= 60'(prod);
          state <= manual_mode ? ST_MAN_SET : ST_M_VS;
        end
        ST_MAN_SET: begin
          mv <= man_v_sat;
          ma <= man_a_sat;
          state <= ST_VEC_INIT;
        end
        ST_M_VS: begin
          tv <= rnd30(acc - 60'(prod));
          state <= ST_M_AC;
        end
        ST_M_AC: begin
          acc <= 60'(prod);
          state <= ST_M_TVS;
        end
        ST_M_TVS: begin
          ta <= rnd30(acc + 60'(prod));
          state <= ST_DIV_V_LD;
        end
        ST_DIV_V_LD, ST_A_LD, ST_X_LD: begin
          dn <= dn_load;
          div_neg <= ld_neg;
          case (state)
            ST_DIV_V_LD: state <= ST_DIV_V;
            ST_A_LD:     state <= ST_DIV_A;
            default:     state <= ST_DIV_X;
          endcase
        end
        ST_DIV_V, ST_DIV_A, ST_DIV_X: begin
          // reciprocal product lands in prod for the next state
          case (state)
            ST_DIV_V: state <= ST_SET_V;
            ST_DIV_A: state <= ST_SET_A;
            default:  state <= ST_SET_X;
          endcase
        end
        ST_SET_V: begin
          mv <= quot_sat;
          state <= ST_A_LD;
        end
        ST_SET_A: begin
          ma <= quot_sat;
          state <= ST_VEC_INIT;
        end
        ST_VEC_INIT: begin
          zero_vec <= (ma == 16'sd0) && (mv == 16'sd0);
          if (ma < 16'sd0) begin
            cz <= (mv >= 16'sd0) ? 22'sd737280 : -22'sd737280;
            cx <= (-33'(ma)) <<< 14;
            cy <= (-33'(mv)) <<< 14;
          end else begin
            cz <= '0;
            cx <= 33'(ma) <<< 14;
            cy <= 33'(mv) <<< 14;
          end
          it <= '0;
          state <= ST_VEC;
        end
        ST_VEC: begin
          if (cy > 33'sd0) begin
            cx <= cx + (cy >>> it);
            cy <= cy - (cx >>> it);
            cz <= cz + atan_s;
          end else begin
            cx <= cx - (cy >>> it);
            cy <= cy + (cx >>> it);
            cz <= cz - atan_s;
          end
          it <= it + 1'b1;
          if (it == 4'(vahc_pkg::ITER - 1)) state <= ST_HUE;
        end
        ST_HUE: begin
          hue <= 21'(h1);
          state <= ST_SQ;
        end
        ST_SQ: begin
          sq_n <= prod[32:0];
          state <= ST_SQRT_INIT;
        end
        ST_SQRT_INIT: begin
          sq_n <= sq_n + prod[32:0];
          sqr_res <= '0;
          sqr_bit <= 33'd1 << 30;
          it <= '0;
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_n >= sq_trial) begin
            sq_n <= sq_n - sq_trial;
            sqr_res <= (sqr_res >> 1) + sqr_bit;
          end else begin
            sqr_res <= sqr_res >> 1;
          end
          sqr_bit <= sqr_bit >> 2;
          it <= it + 1'b1;
          if (it == 4'(vahc_pkg::ITER - 1)) state <= ST_SEC;
        end
        ST_SEC: begin
          sat_c <= sm_comb;
          sector <= sec_comb;
          state <= ST_X_LD;
        end
        ST_SET_X: begin
          case (sector)
            3'd0: begin
              red <= sat_c + mval; yellow <= xx + mval; blue <= mval;
            end
            3'd1: begin
              red <= xx + mval; yellow <= sat_c + mval; blue <= mval;
            end
            3'd2: begin
              red <= mval; yellow <= sat_c + mval; blue <= xx + mval;
            end
            3'd3: begin
              red <= mval; yellow <= xx + mval; blue <= sat_c + mval;
            end
            3'd4: begin
              red <= xx + mval; yellow <= mval; blue <= sat_c + mval;
            end
            default: begin
              red <= sat_c + mval; yellow <= mval; blue <= xx + mval;
            end
          endcase
          valence_sum <= '0;
          arousal_sum <= '0;
          out_valid <= 1'b1;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            out_valid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `VAHC_ASSERT_IMP(a_busy_while_out, m_axis_tvalid, !s_axis_tready, "item taken while result pending")
  `VAHC_ASSERT_IMP(a_count_range, 1'b1, frame_count < CW'(FRAMES), "frame count past run length")
  `VAHC_ASSERT_IMP(a_colour_range, m_axis_tvalid, (red <= 15'd16384) && (yellow <= 15'd16384) && (blue <= 15'd16384), "colour component above one")
  `VAHC_ASSERT_IMP(a_sums_cleared, m_axis_tvalid, (valence_sum == '0) && (arousal_sum == '0), "sums not cleared at result")
  `VAHC_ASSERT_NXT(a_out_taken, m_axis_tvalid && m_axis_tready, !m_axis_tvalid && s_axis_tready, "result not retired")

endmodule

FILE: verif/tb_top.sv
// self-checking bench for the hue colour core: frame pairs in, colours out
// depends on vahc_pkg and vector_average_to_hue_colour_core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFR = vahc_pkg::FRAMES_DEFAULT;
  localparam longint ANG_DEG = 4096;

  typedef struct {
    logic [14:0] red;
    logic [14:0] yellow;
    logic [14:0] blue;
    logic signed [15:0] mean_valence;
    logic signed [15:0] mean_arousal;
  } colour_t;

  // shift toward minus infinity
  function automatic longint floor_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint round_div(longint n, longint d);
    longint q;
    q = n + d / 2;
    if (q >= 0) return q / d;
    return -((-q + d - 1) / d);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint atan_q(int i);
    longint t[16] = '{184320, 108810, 57492, 29184, 14649, 7331, 3667, 1833,
                      917, 458, 229, 115, 57, 29, 14, 7};
    return t[i];
  endfunction

  class colour_scoreboard;
    bit manual;
    int angle16;
    longint radius, gain;
    longint sum_v, sum_a;
    int frames_seen;
    colour_t pending[$];
    int errors;

    function void clear_state();
      manual = 0; angle16 = 0; radius = 16384; gain = 4096;
      sum_v = 0; sum_a = 0; frames_seen = 0;
    endfunction

    function void write_reg(vahc_pkg::cfg_idx_t idx, logic [15:0] d);
      case (idx)
        vahc_pkg::CFG_MANUAL_MODE: manual = d[0];
        vahc_pkg::CFG_ROT_ANGLE: angle16 = int'($signed(d[13:0]));
        vahc_pkg::CFG_RADIUS: radius = d[14:0];
        vahc_pkg::CFG_SCALE: gain = d;
        default: ;
      endcase
    endfunction

    function void rotor(output longint c, output longint s);
      int r;
      bit flip;
      longint x, y, z, t;
      r = angle16 % 5760;
      flip = 0;
      if (r < 0) r += 5760;
      if (r > 2880) r -= 5760;
      if (r > 1440) begin r -= 2880; flip = 1; end
      else if (r < -1440) begin r += 2880; flip = 1; end
      x = 652032874; y = 0; z = longint'(r) * 256;
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          t = x - floor_shr(y, i); y = y + floor_shr(x, i); z -= atan_q(i);
        end else begin
          t = x + floor_shr(y, i); y = y - floor_shr(x, i); z += atan_q(i);
        end
        x = t;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint hue_angle(longint x, longint y);
      longint z, t;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? 180 * ANG_DEG : -180 * ANG_DEG; x = -x; y = -y;
      end
      x *= 16384; y *= 16384;
      for (int i = 0; i < 16; i++) begin
        if (y > 0) begin
          t = x + floor_shr(y, i); y = y - floor_shr(x, i); z += atan_q(i);
        end else begin
          t = x - floor_shr(y, i); y = y + floor_shr(x, i); z -= atan_q(i);
        end
        x = t;
      end
      return z;
    endfunction

    function longint int_sqrt(longint n);
      longint res, b;
      res = 0; b = longint'(1) << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin n -= res + b; res = (res >> 1) + b; end
        else res >>= 1;
        b >>= 2;
      end
      return res;
    endfunction

    function void note_pair(logic signed [15:0] ar, logic signed [15:0] va);
      longint c, s, mv, ma, h, cc, xx, tm, m, r, yl, b, tv, ta;
      colour_t e;
      sum_v += va; sum_a += ar;
      frames_seen = (frames_seen + 1) & 63;
      if ((frames_seen == 0 ? 64 : frames_seen) < NFR) return;
      frames_seen = 0;
      rotor(c, s);
      if (!manual) begin
        tv = round_div(sum_v * c - sum_a * s, longint'(1) << 30);
        ta = round_div(sum_v * s + sum_a * c, longint'(1) << 30);
        mv = clip(round_div(tv * gain, NFR * ANG_DEG), -32768, 16384);
        ma = clip(round_div(ta * gain, NFR * ANG_DEG), -32768, 16384);
      end else begin
        mv = clip(round_div(radius * c, longint'(1) << 30), -32768, 32767);
        ma = clip(round_div(radius * s, longint'(1) << 30), -32768, 32767);
      end
      sum_v = 0; sum_a = 0;
      h = hue_angle(ma, mv) + 30 * ANG_DEG;
      if (h < 0) h += 360 * ANG_DEG;
      if (h >= 360 * ANG_DEG) h -= 360 * ANG_DEG;
      if (h < 0) h = 0;
      cc = clip(int_sqrt(mv * mv + ma * ma), 9830, 16384);
      tm = h % (120 * ANG_DEG) - 60 * ANG_DEG;
      if (tm < 0) tm = -tm;
      xx = round_div(cc * (60 * ANG_DEG - tm), 60 * ANG_DEG);
      m = 16384 - cc;
      r = 0; yl = 0; b = 0;
      case (int'(h / (60 * ANG_DEG)))
        0: begin r = cc; yl = xx; end
        1: begin r = xx; yl = cc; end
        2: begin yl = cc; b = xx; end
        3: begin yl = xx; b = cc; end
        4: begin r = xx; b = cc; end
        default: begin r = cc; b = xx; end
      endcase
      e.red = 15'(r + m); e.yellow = 15'(yl + m); e.blue = 15'(b + m);
      e.mean_valence = 16'(mv); e.mean_arousal = 16'(ma);
      pending = {pending, e};
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    task check_colour(logic [79:0] d);
      colour_t e;
      if (pending.size() == 0) begin
        report("unexpected colour", d[14:0], -1);
        return;
      end
      e = pending.pop_front();
      if (d[14:0] !== e.red) report("red", d[14:0], e.red);
      if (d[29:15] !== e.yellow) report("yellow", d[29:15], e.yellow);
      if (d[44:30] !== e.blue) report("blue", d[44:30], e.blue);
      if (d[60:45] !== e.mean_valence)
        report("mean_valence", $signed(d[60:45]), e.mean_valence);
      if (d[76:61] !== e.mean_arousal)
        report("mean_arousal", $signed(d[76:61]), e.mean_arousal);
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [79:0] m_axis_tdata;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  colour_scoreboard colours = new();
  int pairs_sent, colours_seen;
  bit draining;

  vector_average_to_hue_colour_core dut (.*);

  always #4 clk = ~clk;

  initial begin
    #20ms;
    $display("vector_average_to_hue_colour_core verification failed");
    $finish;
  end

  // receiver: random stall pattern, with a fully ready stretch at times
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      colours.check_colour(m_axis_tdata);
      colours_seen++;
    end
    m_axis_tready <= draining || ($urandom_range(0, 3) != 0) ||
                     ((colours_seen % 5) == 2);
  end

  task send_pair(logic signed [15:0] ar, logic signed [15:0] va);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {va, ar};
    do @(posedge clk); while (!s_axis_tready);
    colours.note_pair(ar, va);
    pairs_sent++;
  endtask

  task pause_sender();
    s_axis_tvalid <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  // wait for all colours, then a margin for any closing computation
  task settle();
    s_axis_tvalid <= 0;
    while (colours.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task write_reg(vahc_pkg::cfg_idx_t idx, logic [15:0] d);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    colours.write_reg(idx, d);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  task run_frames(int n);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 2) != 0) pause_sender();
      end
      burst--;
      send_pair(rand_field(), rand_field());
    end
  endtask

  initial begin
    logic [15:0] dir_a[12], dir_v[12];
    colours.clear_state();
    draining = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: zero vector, extremes, signs on each axis
    dir_a = '{16'h0000, 16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'h4000,
              16'hc000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h2000};
    dir_v = '{16'h0000, 16'h7fff, 16'h8000, 16'h4000, 16'hc000, 16'h0000,
              16'h0000, 16'h8000, 16'h7fff, 16'hffff, 16'h0001, 16'he000};
    for (int k = 0; k < NFR; k++) send_pair(16'h0000, 16'h0000);
    for (int i = 0; i < 12; i++)
      for (int k = 0; k < NFR / 4; k++) send_pair(dir_a[i], dir_v[i]);
    settle();
    // auto phases across angle and gain extremes
    write_reg(vahc_pkg::CFG_SCALE, 16'hffff);
    write_reg(vahc_pkg::CFG_ROT_ANGLE, 16'(-5760));
    run_frames(48);
    settle();
    write_reg(vahc_pkg::CFG_SCALE, 16'h0000);
    write_reg(vahc_pkg::CFG_ROT_ANGLE, 16'(5760));
    run_frames(24);
    settle();
    write_reg(vahc_pkg::CFG_SCALE, 16'h1800);
    write_reg(vahc_pkg::CFG_ROT_ANGLE, 16'h3fff);
    run_frames(72);
    settle();
    // manual phases, including radius above one and ignored upper bits
    write_reg(vahc_pkg::CFG_MANUAL_MODE, 16'hfffe);
    write_reg(vahc_pkg::CFG_MANUAL_MODE, 16'h0001);
    for (int p = 0; p < 6; p++) begin
      write_reg(vahc_pkg::CFG_RADIUS, p == 0 ? 16'h0000 : p == 1 ? 16'h7fff :
                p == 2 ? 16'h4000 : 16'($urandom));
      write_reg(vahc_pkg::CFG_ROT_ANGLE, p == 3 ? 16'h2000 : 16'($urandom));
      run_frames(16);
      settle();
    end
    // random auto settings
    write_reg(vahc_pkg::CFG_MANUAL_MODE, 16'h0000);
    for (int p = 0; p < 6; p++) begin
      write_reg(vahc_pkg::CFG_ROT_ANGLE, 16'($urandom));
      write_reg(vahc_pkg::CFG_SCALE, 16'($urandom));
      write_reg(vahc_pkg::CFG_RADIUS, 16'($urandom));
      run_frames(24);
      settle();
    end
    draining = 1;
    settle();
    $display("sent %0d frame pairs, checked %0d colours", pairs_sent, colours_seen);
    $display("covered auto and manual modes, angle and gain extremes, random stalls");
    if (colours.errors == 0 && colours.pending.size() == 0)
      $display("vector_average_to_hue_colour_core verification clean");
    else
      $display("vector_average_to_hue_colour_core verification failed");
    $finish;
  end
endmodule

FILE: vector_average_to_hue_colour_core.f
+incdir+src
src/vahc_pkg.sv
src/vector_average_to_hue_colour_core.sv
verif/tb_top.sv
